// ----- rtl/core/ptu_pkg.sv -----
// ----------------------------------------------------------------------------
// ptu_pkg: shared types and constants of the particle tween update block
// Sequencer states, arithmetic step codes, ease modes and register reset values.
// ----------------------------------------------------------------------------
package ptu_pkg;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // Multiply steps run by the sequencer, in order
  typedef enum logic [3:0] {
    OP_P2    = 4'd0,
    OP_P3    = 4'd1,
    OP_Q2    = 4'd2,
    OP_Q3    = 4'd3,
    OP_SPD   = 4'd4,
    OP_SX    = 4'd5,
    OP_SY    = 4'd6,
    OP_MDT   = 4'd7,
    OP_PX    = 4'd8,
    OP_PY    = 4'd9,
    OP_ANG   = 4'd10,
    OP_ALPHA = 4'd11,
    OP_FRAME = 4'd12
  } op_e;

  // Ease modes
  localparam logic [1:0] EASE_IN  = 2'd1;
  localparam logic [1:0] EASE_OUT = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LIFETIME = 3'd0;
  localparam logic [2:0] REG_SPEED    = 3'd1;
  localparam logic [2:0] REG_SCALE_X  = 3'd2;
  localparam logic [2:0] REG_SCALE_Y  = 3'd3;
  localparam logic [2:0] REG_HEADING  = 3'd4;
  localparam logic [2:0] REG_SPIN     = 3'd5;
  localparam logic [2:0] REG_FADE     = 3'd6;
  localparam logic [2:0] REG_EASE     = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_LIFETIME = 24'd19661;
  localparam logic [31:0] RST_SPEED    = 32'h6400_3200;
  localparam logic [31:0] RST_SCALE    = 32'h1000_1000;
  localparam logic [31:0] RST_HEADING  = 32'h0000_4000;
  localparam logic [15:0] RST_SPIN     = 16'h0000;
  localparam logic [16:0] RST_FADE     = 17'h1FFFF;
  localparam logic [9:0]  RST_EASE     = 10'h201;

  // Operand widths of the serial multiplier
  localparam int unsigned MUL_AW = 33;
  localparam int unsigned MUL_BW = 18;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

endpackage

// ----- rtl/core/ptu_stream_if.sv -----
// ----------------------------------------------------------------------------
// ptu_stream_if: valid/ready channels of the particle tween update block
// Input tick channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface ptu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] delta_time;

  modport source (output valid, output delta_time, input ready);
  modport sink   (input valid, input delta_time, output ready);
endinterface

interface ptu_out_if;
  logic               valid;
  logic               ready;
  logic               dead;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading_angle;
  logic signed [15:0] eased_speed;
  logic        [15:0] size_x;
  logic        [15:0] size_y;
  logic        [15:0] opacity;
  logic        [7:0]  frame_index;

  modport source (output valid, output dead, output pos_x, output pos_y,
                  output heading_angle, output eased_speed, output size_x,
                  output size_y, output opacity, output frame_index, input ready);
  modport sink   (input valid, input dead, input pos_x, input pos_y,
                  input heading_angle, input eased_speed, input size_x,
                  input size_y, input opacity, input frame_index, output ready);
endinterface

// ----- rtl/core/ptu_div.sv -----
// ----------------------------------------------------------------------------
// ptu_div: bit-serial restoring divider
// Forms floor(num * 65536 / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [23:0] rem_q, rem_d;
  logic [23:0] den_q;
  logic [15:0] quot_q, quot_d;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [24:0] trial;
  logic        take;

  // Shift remainder left, subtract divisor when it fits
  always_comb begin
    trial  = {rem_q, 1'b0};
    take   = trial >= {1'b0, den_q};
    rem_d  = take ? 24'(trial - {1'b0, den_q}) : trial[23:0];
    quot_d = {quot_q[14:0], take};
  end

  // Control: count sixteen quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/ptu_mul.sv -----
// ----------------------------------------------------------------------------
// ptu_mul: bit-serial signed multiplier
// Shift-add over the bits of b, most significant first, one bit per cycle.
// ----------------------------------------------------------------------------
module ptu_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [ptu_pkg::MUL_AW-1:0]     a_i,
  input  logic signed [ptu_pkg::MUL_BW-1:0]     b_i,
  output logic                                  done_o,
  output logic signed [ptu_pkg::MUL_PW-1:0]     prod_o
);
  import ptu_pkg::*;

  localparam int unsigned CW = $clog2(MUL_BW + 1);

  logic signed [MUL_PW-1:0] acc_q, acc_d;
  logic signed [MUL_PW-1:0] a_q;
  logic        [MUL_BW-1:0] b_q;
  logic        [CW-1:0]     cnt_q;
  logic                     busy_q, done_q;
  logic signed [MUL_PW-1:0] addend;

  // Sign bit of b carries negative weight
  always_comb begin
    if (!b_q[MUL_BW-1]) begin
      addend = '0;
    end else if (cnt_q == CW'(MUL_BW)) begin
      addend = -a_q;
    end else begin
      addend = a_q;
    end
    acc_d = (acc_q <<< 1) + addend;
  end

  // Control: count the bits of b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MUL_BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Accumulate and shift the multiplier bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= MUL_PW'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[MUL_BW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/core/particle_tween_update.sv -----
// ----------------------------------------------------------------------------
// particle_tween_update: per-tick update of one eased particle
// Ages the particle and eases speed, scale, position, angle, alpha and frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick (delta_time); out_ch returns one result per tick.
//   Both are valid/ready; a transfer happens when valid and ready are high.
//   The user writes registers via cfg_we_i/cfg_idx_i/cfg_data_i only while idle; not enforced.
// Timing:
//   A tick that leaves the particle dead goes from idle to the output state, and
//   its result loads there once the output register is free. A live tick runs a
//   serial divide for the progress (start, one quotient bit per step, hand-off),
//   then 13 multiplies on one 18-bit serial shift-add multiplier (start, one bit
//   of b per step, hand-off), then enters the output state and loads likewise.
//   A new tick is taken once the previous result sits in the output register,
//   so the block takes no new tick while a result is still being formed.
// Reset:
//   Registers take their default values, age, position and angle clear and the
//   held speed, scale and alpha take the start values of the defaults.
// Stall:
//   A waiting result holds in the output register; a finished next result
//   waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module particle_tween_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  ptu_in_if.sink       in_ch,
  ptu_out_if.source    out_ch
);
  import ptu_pkg::*;

  // Configuration registers
  logic [23:0] life_q;
  logic [31:0] speed_q, sx_q, sy_q, head_q;
  logic [15:0] spin_q;
  logic [16:0] fade_q;
  logic [9:0]  ease_q;

  // Particle state
  logic [23:0] age_q;
  logic [31:0] px_q, py_q;
  logic [15:0] ang_q, hspd_q, hsx_q, hsy_q, halpha_q;
  logic [7:0]  hframe_q;

  // Sequencer
  state_e state_q;
  op_e    op_q;
  logic   issued_q;
  logic   dead_q;
  logic [15:0] dt_q, p_q, p2_q, p3_q;
  logic [16:0] q2_q, q3_q;
  logic signed [32:0] m_q;

  // Output register
  logic               ovalid_q, odead_q;
  logic [31:0]        opx_q, opy_q;
  logic [15:0]        oang_q, ospd_q, osx_q, osy_q, oalpha_q;
  logic [7:0]         oframe_q;

  logic [24:0] age_sum;
  logic [23:0] age_nxt;
  logic        alive, in_xfer, out_free;
  logic        div_start, div_done, mul_start, mul_done;
  logic [15:0] quot;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic [16:0] q, f, d_spd, d_sx, d_sy, inv_p3;
  logic [31:0] step, ang_rnd;
  logic [7:0]  fr, cnt_m1;

  // Saturating age and liveness of the incoming tick
  assign age_sum = {1'b0, age_q} + {9'b0, in_ch.delta_time};
  assign age_nxt = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
  assign alive   = age_nxt < life_q;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_q || out_ch.ready;

  assign div_start = (state_q == ST_DIV) && !issued_q;
  assign mul_start = (state_q == ST_MUL) && !issued_q;

  ptu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (age_q),
    .den_i   (life_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  ptu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Ease factor and differences
  always_comb begin
    q      = 17'h10000 - {1'b0, p_q};
    inv_p3 = 17'h10000 - {1'b0, p3_q};
    case (ease_q[9:8])
      EASE_IN:  f = {1'b0, p3_q};
      EASE_OUT: f = 17'h10000 - q3_q;
      default:  f = {1'b0, p_q};
    endcase
    d_spd = {speed_q[15], speed_q[15:0]} - {speed_q[31], speed_q[31:16]};
    d_sx  = {1'b0, sx_q[15:0]} - {1'b0, sx_q[31:16]};
    d_sy  = {1'b0, sy_q[15:0]} - {1'b0, sy_q[31:16]};
  end

  // Select multiplier operands for the current step
  always_comb begin
    case (op_q)
      OP_P2:    begin mul_a = {17'b0, p_q};  mul_b = {2'b0, p_q}; end
      OP_P3:    begin mul_a = {17'b0, p2_q}; mul_b = {2'b0, p_q}; end
      OP_Q2:    begin mul_a = {16'b0, q};    mul_b = {1'b0, q}; end
      OP_Q3:    begin mul_a = {16'b0, q2_q}; mul_b = {1'b0, q}; end
      OP_SPD:   begin mul_a = {{16{d_spd[16]}}, d_spd}; mul_b = {1'b0, f}; end
      OP_SX:    begin mul_a = {{16{d_sx[16]}}, d_sx};   mul_b = {1'b0, f}; end
      OP_SY:    begin mul_a = {{16{d_sy[16]}}, d_sy};   mul_b = {1'b0, f}; end
      OP_MDT:   begin mul_a = {{17{hspd_q[15]}}, hspd_q}; mul_b = {2'b0, dt_q}; end
      OP_PX:    begin mul_a = m_q; mul_b = {{2{head_q[31]}}, head_q[31:16]}; end
      OP_PY:    begin mul_a = m_q; mul_b = {{2{head_q[15]}}, head_q[15:0]}; end
      OP_ANG:   begin mul_a = {{17{spin_q[15]}}, spin_q}; mul_b = {2'b0, dt_q}; end
      OP_ALPHA: begin mul_a = {16'b0, inv_p3}; mul_b = {2'b0, fade_q[16:1]}; end
      OP_FRAME: begin mul_a = {25'b0, ease_q[7:0]}; mul_b = {2'b0, p_q}; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Result shaping: floor shifts, rounding and frame cap
  assign step    = {{3{prod[50]}}, prod[50:22]};
  assign ang_rnd = prod[31:0] + 32'h0000_8000;
  assign cnt_m1  = ease_q[7:0] - 8'd1;
  assign fr      = (prod[23:16] > cnt_m1) ? cnt_m1 : prod[23:16];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q  <= RST_LIFETIME;
      speed_q <= RST_SPEED;
      sx_q    <= RST_SCALE;
      sy_q    <= RST_SCALE;
      head_q  <= RST_HEADING;
      spin_q  <= RST_SPIN;
      fade_q  <= RST_FADE;
      ease_q  <= RST_EASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LIFETIME: life_q  <= cfg_data_i[23:0];
        REG_SPEED:    speed_q <= cfg_data_i;
        REG_SCALE_X:  sx_q    <= cfg_data_i;
        REG_SCALE_Y:  sy_q    <= cfg_data_i;
        REG_HEADING:  head_q  <= cfg_data_i;
        REG_SPIN:     spin_q  <= cfg_data_i[15:0];
        REG_FADE:     fade_q  <= cfg_data_i[16:0];
        REG_EASE:     ease_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_P2;
      issued_q <= 1'b0;
      dead_q   <= 1'b0;
      age_q    <= '0;
      px_q     <= '0;
      py_q     <= '0;
      ang_q    <= '0;
      hspd_q   <= RST_SPEED[31:16];
      hsx_q    <= RST_SCALE[31:16];
      hsy_q    <= RST_SCALE[31:16];
      halpha_q <= RST_FADE[16:1];
      hframe_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            age_q    <= age_nxt;
            dead_q   <= !alive;
            issued_q <= 1'b0;
            state_q  <= alive ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          issued_q <= !div_done;
          if (div_done) begin
            op_q     <= OP_P2;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          issued_q <= !mul_done;
          if (mul_done) begin
            op_q     <= op_e'(op_q + 4'd1);
            case (op_q)
              OP_SPD:   hspd_q <= speed_q[31:16] + prod[31:16];
              OP_SX:    hsx_q  <= sx_q[31:16] + prod[31:16];
              OP_SY:    hsy_q  <= sy_q[31:16] + prod[31:16];
              OP_PX:    px_q   <= px_q + step;
              OP_PY:    py_q   <= py_q + step;
              OP_ANG:   ang_q  <= ang_q + ang_rnd[31:16];
              OP_ALPHA: if (fade_q[0]) halpha_q <= prod[31:16];
              OP_FRAME: begin
                hframe_q <= (ease_q[7:0] == 8'd0) ? 8'd0 : fr;
                state_q  <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Working values of the live computation
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dt_q <= in_ch.delta_time;
    end
    if (div_done) begin
      p_q <= quot;
    end
    if (mul_done) begin
      case (op_q)
        OP_P2:  p2_q <= prod[31:16];
        OP_P3:  p3_q <= prod[31:16];
        OP_Q2:  q2_q <= prod[32:16];
        OP_Q3:  q3_q <= prod[32:16];
        OP_MDT: m_q  <= prod[32:0];
        default: ;
      endcase
    end
  end

  // Output register: load when free, drop valid on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      ovalid_q <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      odead_q  <= dead_q;
      opx_q    <= px_q;
      opy_q    <= py_q;
      oang_q   <= ang_q;
      ospd_q   <= hspd_q;
      osx_q    <= hsx_q;
      osy_q    <= hsy_q;
      oalpha_q <= halpha_q;
      oframe_q <= hframe_q;
    end
  end

  assign out_ch.valid         = ovalid_q;
  assign out_ch.dead          = odead_q;
  assign out_ch.pos_x         = opx_q;
  assign out_ch.pos_y         = opy_q;
  assign out_ch.heading_angle = oang_q;
  assign out_ch.eased_speed   = ospd_q;
  assign out_ch.size_x        = osx_q;
  assign out_ch.size_y        = osy_q;
  assign out_ch.opacity       = oalpha_q;
  assign out_ch.frame_index   = oframe_q;

  // Serial units only finish in the state that waits for them
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply steps");

  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q |-> (state_q == ST_DIV || state_q == ST_MUL))
    else $error("unit marked busy while the sequencer is not waiting");

  a_dead_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !alive) |=> state_q == ST_OUT)
    else $error("dead tick did not go straight to the output");

endmodule

// ----- tb/particle_tween_update_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_tween_update_tb: self-checking bench of the particle tick update
// Sends ticks over the valid/ready input channel with random gaps, predicts
// each result with an in-bench model of aging, easing and motion, and compares
// every result field. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module particle_tween_update_tb;
  import ptu_pkg::*;

  localparam int NUM_RANDOM = 1700;
  localparam int DRAIN_CYC  = 400;

  typedef struct packed {
    logic        dead;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading_angle;
    logic [15:0] eased_speed;
    logic [15:0] size_x;
    logic [15:0] size_y;
    logic [15:0] opacity;
    logic [7:0]  frame_index;
  } update_t;

  typedef struct {
    logic [15:0] dt;
    bit          known;
    logic        dead;
    logic [15:0] opacity;
  } tick_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  ptu_in_if  in_ch ();
  ptu_out_if out_ch ();

  particle_tween_update u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  // Predictor copy of registers and particle state
  logic [23:0] m_life;
  logic [31:0] m_speed, m_sx, m_sy, m_head;
  logic [15:0] m_spin;
  logic [16:0] m_fade;
  logic [9:0]  m_ease;
  logic [23:0] m_age;
  logic [31:0] m_px, m_py;
  logic [15:0] m_ang, m_spd, m_scx, m_scy, m_alpha;
  logic [7:0]  m_frame;

  update_t expected_updates[$];
  bit      known_dead[$];
  logic [15:0] known_opacity[$];
  bit      known_flag[$];

  int  error_count;
  int  ticks_sent;
  int  updates_seen;
  int  dead_seen;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint floor_shift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint cube16(longint v);
    longint v2;
    v2 = (v * v) >>> 16;
    return (v2 * v) >>> 16;
  endfunction

  function automatic longint ease_value(longint s, longint t, longint f);
    return s + floor_shift((t - s) * f, 16);
  endfunction

  task automatic model_reset();
    m_life = RST_LIFETIME; m_speed = RST_SPEED; m_sx = RST_SCALE; m_sy = RST_SCALE;
    m_head = RST_HEADING; m_spin = RST_SPIN; m_fade = RST_FADE; m_ease = RST_EASE;
    m_age = '0; m_px = '0; m_py = '0; m_ang = '0;
    m_spd = m_speed[31:16]; m_scx = m_sx[31:16]; m_scy = m_sy[31:16];
    m_alpha = m_fade[16:1]; m_frame = '0;
  endtask

  // Advance the particle by one tick and return the expected result
  function automatic update_t predict_tick(logic [15:0] dt);
    update_t r;
    longint sum, p, p3, f, spd, step, ang, cnt, fr;
    sum = longint'(m_age) + longint'(dt);
    m_age = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
    r.dead = 1'b1;
    if (m_age < m_life) begin
      r.dead = 1'b0;
      p  = (longint'(m_age) << 16) / longint'(m_life);
      p3 = cube16(p);
      if (m_ease[9:8] == EASE_IN) f = p3;
      else if (m_ease[9:8] == EASE_OUT) f = 65536 - cube16(65536 - p);
      else f = p;
      spd = ease_value(longint'($signed(m_speed[31:16])),
                       longint'($signed(m_speed[15:0])), f);
      m_spd = spd[15:0];
      step  = ease_value(longint'(m_sx[31:16]), longint'(m_sx[15:0]), f);
      m_scx = step[15:0];
      step  = ease_value(longint'(m_sy[31:16]), longint'(m_sy[15:0]), f);
      m_scy = step[15:0];
      step = floor_shift(spd * longint'(dt) * longint'($signed(m_head[31:16])), 22);
      m_px = m_px + step[31:0];
      step = floor_shift(spd * longint'(dt) * longint'($signed(m_head[15:0])), 22);
      m_py = m_py + step[31:0];
      ang = floor_shift(longint'($signed(m_spin)) * longint'(dt) + 32768, 16);
      m_ang = m_ang + ang[15:0];
      if (m_fade[0]) begin
        step = ((65536 - p3) * longint'(m_fade[16:1])) >>> 16;
        m_alpha = step[15:0];
      end
      cnt = longint'(m_ease[7:0]);
      if (cnt == 0) m_frame = '0;
      else begin
        fr = (cnt * p) >>> 16;
        if (fr > cnt - 1) fr = cnt - 1;
        m_frame = fr[7:0];
      end
    end
    r.pos_x = m_px; r.pos_y = m_py; r.heading_angle = m_ang;
    r.eased_speed = m_spd; r.size_x = m_scx; r.size_y = m_scy;
    r.opacity = m_alpha; r.frame_index = m_frame;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on update %0d: %s got %0h want %0h",
             updates_seen, field, got, want);
    error_count++;
  endtask

  // Sink side: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    update_t w;
    bit kf;
    logic kd;
    logic [15:0] ko;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected update", 1, 0);
      end else begin
        w = expected_updates.pop_front();
        kf = known_flag.pop_front(); kd = known_dead.pop_front();
        ko = known_opacity.pop_front();
        if (kf && w.dead !== kd) report_mismatch("table dead", w.dead, kd);
        if (kf && w.opacity !== ko) report_mismatch("table opacity", w.opacity, ko);
        if (out_ch.dead !== w.dead) report_mismatch("dead", out_ch.dead, w.dead);
        if (out_ch.pos_x !== w.pos_x) report_mismatch("pos_x", out_ch.pos_x, w.pos_x);
        if (out_ch.pos_y !== w.pos_y) report_mismatch("pos_y", out_ch.pos_y, w.pos_y);
        if (out_ch.heading_angle !== w.heading_angle)
          report_mismatch("heading_angle", out_ch.heading_angle, w.heading_angle);
        if (out_ch.eased_speed !== w.eased_speed)
          report_mismatch("eased_speed", out_ch.eased_speed, w.eased_speed);
        if (out_ch.size_x !== w.size_x) report_mismatch("size_x", out_ch.size_x, w.size_x);
        if (out_ch.size_y !== w.size_y) report_mismatch("size_y", out_ch.size_y, w.size_y);
        if (out_ch.opacity !== w.opacity)
          report_mismatch("opacity", out_ch.opacity, w.opacity);
        if (out_ch.frame_index !== w.frame_index)
          report_mismatch("frame_index", out_ch.frame_index, w.frame_index);
        if (w.dead) dead_seen++;
      end
      updates_seen++;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 28);
  end

  // Push one tick through the input channel, with an optional random gap;
  // valid stays up after the transfer until the next tick or an idle wait
  task automatic send_tick(logic [15:0] dt, bit kf, logic kd, logic [15:0] ko);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.delta_time <= dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_updates.push_back(predict_tick(dt));
    known_flag.push_back(kf); known_dead.push_back(kd); known_opacity.push_back(ko);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LIFETIME: m_life  = data[23:0];
      REG_SPEED:    m_speed = data;
      REG_SCALE_X:  m_sx    = data;
      REG_SCALE_Y:  m_sy    = data;
      REG_HEADING:  m_head  = data;
      REG_SPIN:     m_spin  = data[15:0];
      REG_FADE:     m_fade  = data[16:0];
      default:      m_ease  = data[9:0];
    endcase
    @(negedge clk_i);
  endtask

  // Random register set; small lifetimes keep the particle dying and saturating
  task automatic random_config(int phase);
    logic [23:0] life;
    case (phase % 4)
      0: life = 24'($urandom_range(1, 200));
      1: life = 24'($urandom_range(1000, 300000));
      2: life = 24'hFFFFFF;
      default: life = 24'($urandom_range(1, 24'hFFFFFF));
    endcase
    write_reg(REG_LIFETIME, {8'h00, life});
    write_reg(REG_SPEED, $urandom());
    write_reg(REG_SCALE_X, $urandom());
    write_reg(REG_SCALE_Y, $urandom());
    write_reg(REG_HEADING, $urandom());
    write_reg(REG_SPIN, $urandom_range(0, 16'hFFFF));
    write_reg(REG_FADE, $urandom_range(0, 17'h1FFFF));
    write_reg(REG_EASE, {22'h0, 2'(phase % 4), 8'($urandom_range(0, 255))});
  endtask

  // Directed ticks: after reset, extremes and death
  tick_row_t dir_rows[] = '{
    '{16'd0,     1'b1, 1'b0, 16'hFFFF},
    '{16'd1,     1'b0, 1'b0, 16'h0},
    '{16'd1000,  1'b0, 1'b0, 16'h0},
    '{16'd5000,  1'b0, 1'b0, 16'h0},
    '{16'd65535, 1'b1, 1'b1, 16'h0},
    '{16'd0,     1'b1, 1'b1, 16'h0},
    '{16'd65535, 1'b1, 1'b1, 16'h0}
  };

  initial begin
    int n;
    error_count = 0; ticks_sent = 0; updates_seen = 0; dead_seen = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.delta_time = '0; out_ch.ready = 1'b0;
    model_reset();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Table rows; opacity is known only where fixed by the setup
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].dt, dir_rows[i].known, dir_rows[i].dead,
                dir_rows[i].known ? (dir_rows[i].dead ? m_alpha : dir_rows[i].opacity)
                                  : 16'h0);
    end
    wait_idle();

    // Extreme settings: zero frames, mode three, max lifetime, fade off
    write_reg(REG_LIFETIME, 32'h00FFFFFF);
    write_reg(REG_SPEED, 32'h7FFF_8000);
    write_reg(REG_SCALE_X, 32'hFFFF_0000);
    write_reg(REG_SCALE_Y, 32'h0000_FFFF);
    write_reg(REG_HEADING, 32'h8000_7FFF);
    write_reg(REG_SPIN, 32'h0000_8000);
    write_reg(REG_FADE, 32'h0001_FFFE);
    write_reg(REG_EASE, 32'h0000_0300);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_SPIN; cfg_data_i <= 32'h0000_7FFF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0; m_spin = 16'h7FFF;
    for (int i = 0; i < 12; i++)
      send_tick(i[0] ? 16'hFFFF : 16'h0001, 1'b0, 1'b0, 16'h0);
    wait_idle();

    // Random phases of ticks; one stretch without idling
    n = 0;
    for (int ph = 0; n < NUM_RANDOM; ph++) begin
      random_config(ph);
      no_idle = (ph == 3);
      for (int k = 0; k < 60 && n < NUM_RANDOM; k++, n++) begin
        case ($urandom_range(3))
          0: send_tick(16'($urandom_range(0, 15)), 1'b0, 1'b0, 16'h0);
          1: send_tick(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0, 16'h0);
          default: send_tick(16'($urandom_range(0, 2000)), 1'b0, 1'b0, 16'h0);
        endcase
      end
      no_idle = 1'b0;
      wait_idle();
    end

    $display("ticks sent %0d, updates checked %0d, dead updates %0d",
             ticks_sent, updates_seen, dead_seen);
    $display("covered all ease modes, frame counts, fade on/off and lifetime extremes");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
